/* design/trd_pkg.sv */
package trd_pkg;

  localparam int MAX_POINTS_DEF  = 5;
  localparam int FRAME_BYTES_DEF = 32;

  localparam int POS_W     = 6;
  localparam int IDX_W     = 4;
  localparam int COORD_W   = 12;
  localparam int SIZE_W    = 13;
  localparam int ROT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int NIB_W     = 4;

  localparam int HEAD_BYTES  = 2;
  localparam int POINT_BYTES = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [ROT_W-1:0] ROT_PORTRAIT   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_LAND_RIGHT = 2'd1;
  localparam logic [ROT_W-1:0] ROT_FLIPPED    = 2'd2;
  localparam logic [ROT_W-1:0] ROT_LAND_LEFT  = 2'd3;

  // byte of a point record fetched from the frame store
  localparam logic [1:0] SEL_XH = 2'd0;
  localparam logic [1:0] SEL_XL = 2'd1;
  localparam logic [1:0] SEL_YH = 2'd2;
  localparam logic [1:0] SEL_YL = 2'd3;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd172;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd320;

  typedef struct packed {
    logic             wr_en;
    logic             cnt_load;
    logic [POS_W-1:0] wr_addr;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic [1:0]       rd_sel;
    logic             tc_clear;
    logic             tc_load;
    logic             emit;
    logic             emit_point;
    logic             emit_last;
    logic [IDX_W-1:0] emit_idx;
  } trd_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             cnt_ok;
    logic [IDX_W-1:0] cnt_n;
  } trd_stat_t;

  // size - 1 - v, clamped to the coordinate range
  function automatic logic [COORD_W-1:0] mirror_sat(input logic [SIZE_W-1:0] size,
                                                    input logic [COORD_W-1:0] v);
    logic signed [SIZE_W+1:0] r;
    r = $signed({2'b00, size}) - 15'sd1 - $signed({3'b000, v});
    if (r < 15'sd0) begin
      return '0;
    end else if (r > 15'sd4095) begin
      return '1;
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

/* design/trd_ctrl.sv */
module trd_ctrl import trd_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  input  logic      in_line_low,
  output logic      in_ready,
  input  trd_stat_t stat,
  output trd_cmd_t  cmd
);

  localparam int               FRAME_LEN = HEAD_BYTES + POINT_BYTES * MAX_POINTS;
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] COUNT_POS = POS_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EMIT, S_BAD} state_t;
  typedef enum logic [1:0] {FM_NONE, FM_NEW, FM_HELD} frame_mode_t;

  state_t           state_r, state_nxt;
  frame_mode_t      mode_r, mode_nxt;
  logic             prev_high_r, prev_high_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [IDX_W-1:0] pt_r, pt_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic             accept;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    prev_high_nxt = prev_high_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    pt_nxt        = pt_r;
    base_nxt      = base_r;

    in_ready = (state_r == S_IDLE);
    accept   = in_valid && in_ready;

    cmd           = '0;
    cmd.wr_addr   = pos_r;
    cmd.rd_addr   = POS_W'(base_r + POS_W'(step_r));
    cmd.rd_sel    = step_r;
    cmd.emit_idx  = pt_r;
    cmd.emit_last = (IDX_W'(pt_r + IDX_W'(1)) == stat.cnt_n);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_command) begin
            pos_nxt = '0;
            if (in_line_low) begin
              mode_nxt = prev_high_r ? FM_NEW : FM_HELD;
            end else begin
              mode_nxt = FM_NONE;
              if (prev_high_r) begin
                cmd.tc_clear = 1'b1;
              end
            end
            prev_high_nxt = !in_line_low;
          end else if (mode_r != FM_NONE) begin
            cmd.wr_en    = 1'b1;
            cmd.cnt_load = (pos_r == COUNT_POS);
            pos_nxt      = POS_W'(pos_r + POS_W'(1));
            if (pos_r == LAST_POS) begin
              pos_nxt  = '0;
              mode_nxt = FM_NONE;
              if (stat.cnt_ok) begin
                cmd.tc_load = 1'b1;
                step_nxt    = '0;
                pt_nxt      = '0;
                base_nxt    = POS_W'(HEAD_BYTES);
                state_nxt   = S_FETCH;
              end else begin
                if (mode_r == FM_NEW) begin
                  cmd.tc_clear = 1'b1;
                end
                state_nxt = S_BAD;
              end
            end
          end
        end
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        step_nxt  = 2'(step_r + 2'd1);
        if (step_r == SEL_YL) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_point = 1'b1;
          if (cmd.emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            pt_nxt    = IDX_W'(pt_r + IDX_W'(1));
            base_nxt  = POS_W'(base_r + POS_W'(POINT_BYTES));
            state_nxt = S_FETCH;
          end
        end
      end
      S_BAD: begin
        cmd.emit_last = 1'b1;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= FM_NONE;
      prev_high_r <= 1'b1;
      pos_r       <= '0;
      step_r      <= '0;
      pt_r        <= '0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      prev_high_r <= prev_high_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      pt_r        <= pt_nxt;
      base_r      <= base_nxt;
    end
  end

endmodule

/* design/trd_dp.sv */
module trd_dp import trd_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_report_byte,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  trd_cmd_t             cmd,
  output trd_stat_t            stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [COORD_W-1:0]   out_point_x,
  output logic [COORD_W-1:0]   out_point_y,
  output logic [2:0]           out_point_index,
  output logic [2:0]           out_point_count,
  output logic                 out_point_valid,
  output logic                 out_last_point
);

  localparam int             AW        = $clog2(FRAME_BYTES);
  localparam logic [POS_W:0] STORE_LIM = (POS_W + 1)'(FRAME_BYTES);
  localparam logic [7:0]     MAX_CNT   = 8'(MAX_POINTS);

  logic [7:0]         store_mem [FRAME_BYTES];
  logic [7:0]         count_r;
  logic [2:0]         touch_count_r;
  logic [ROT_W-1:0]   rot_r;
  logic [SIZE_W-1:0]  width_r;
  logic [SIZE_W-1:0]  height_r;
  logic [NIB_W-1:0]   xh_r, yh_r;
  logic [7:0]         xl_r, yl_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [2:0]         out_idx_r, out_cnt_r;
  logic               out_pv_r, out_last_r;

  logic               wr_in, rd_in;
  logic [COORD_W-1:0] x, y, rx, ry, mx_w, my_h, mx_wy, my_hx;

  assign wr_in = ({1'b0, cmd.wr_addr} < STORE_LIM);
  assign rd_in = ({1'b0, cmd.rd_addr} < STORE_LIM);

  // frame store; bytes past its end read as zero
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in) begin
      store_mem[cmd.wr_addr[AW-1:0]] <= in_report_byte;
    end
    if (cmd.rd_en) begin
      unique case (cmd.rd_sel)
        SEL_XH:  xh_r <= rd_in ? store_mem[cmd.rd_addr[AW-1:0]][NIB_W-1:0] : '0;
        SEL_XL:  xl_r <= rd_in ? store_mem[cmd.rd_addr[AW-1:0]] : '0;
        SEL_YH:  yh_r <= rd_in ? store_mem[cmd.rd_addr[AW-1:0]][NIB_W-1:0] : '0;
        SEL_YL:  yl_r <= rd_in ? store_mem[cmd.rd_addr[AW-1:0]] : '0;
        default: ;
      endcase
    end
    if (cmd.cnt_load) begin
      count_r <= in_report_byte;
    end
  end

  assign stat.cnt_ok   = (count_r != 8'd0) && (count_r <= MAX_CNT);
  assign stat.cnt_n    = count_r[IDX_W-1:0];
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_count_r <= '0;
      rot_r         <= ROT_PORTRAIT;
      width_r       <= WIDTH_RST;
      height_r      <= HEIGHT_RST;
    end else begin
      if (cmd.tc_clear) begin
        touch_count_r <= '0;
      end else if (cmd.tc_load) begin
        touch_count_r <= count_r[2:0];
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROTATION: rot_r    <= cfg_data[ROT_W-1:0];
          CFG_WIDTH:    width_r  <= cfg_data;
          CFG_HEIGHT:   height_r <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  assign x     = {xh_r, xl_r};
  assign y     = {yh_r, yl_r};
  assign mx_w  = mirror_sat(width_r, x);
  assign my_h  = mirror_sat(height_r, y);
  assign mx_wy = mirror_sat(width_r, y);
  assign my_hx = mirror_sat(height_r, x);

  always_comb begin
    unique case (rot_r)
      ROT_PORTRAIT: begin
        rx = mx_w;
        ry = y;
      end
      ROT_LAND_RIGHT: begin
        rx = y;
        ry = x;
      end
      ROT_FLIPPED: begin
        rx = x;
        ry = my_h;
      end
      ROT_LAND_LEFT: begin
        rx = mx_wy;
        ry = my_hx;
      end
      default: begin
        rx = x;
        ry = y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r    <= cmd.emit_point ? rx : '0;
      out_y_r    <= cmd.emit_point ? ry : '0;
      out_idx_r  <= cmd.emit_point ? cmd.emit_idx[2:0] : '0;
      out_cnt_r  <= touch_count_r;
      out_pv_r   <= cmd.emit_point;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_index = out_idx_r;
  assign out_point_count = out_cnt_r;
  assign out_point_valid = out_pv_r;
  assign out_last_point  = out_last_r;

endmodule

/* design/touch_report_decoder_core.sv */
// Touch report decoder.
// Input channel (in_*): one beat is either an interrupt line sample
// (in_command 0, in_line_low) or one report byte (in_command 1,
// in_report_byte). A low sample opens a frame of 2 + 6*MAX_POINTS bytes.
// Output channel (out_*): one beat per touch point when a frame completes
// with a count of 1..MAX_POINTS, or a single marker beat (point_valid 0)
// for a bad count. last_point flags the final beat of a frame.
// Config (cfg_*): rotation, width, height; always ready, write while idle.
// Samples and bytes are taken one per cycle. The byte that completes a
// frame starts emission: each point is read from the frame store as its
// X high, X low, Y high and Y low bytes (one port, one byte a cycle) and
// then loaded into the output register; a bad count loads a marker. No
// input is taken during emission. A stalled receiver holds the output
// register and emission waits for it. Reset clears output valid, the
// frame state, the touch count and the config registers to 0 / 172 / 320.
module touch_report_decoder_core import trd_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic                 in_line_low,
  input  logic [7:0]           in_report_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_point_x,
  output logic [COORD_W-1:0]   out_point_y,
  output logic [2:0]           out_point_index,
  output logic [2:0]           out_point_count,
  output logic                 out_point_valid,
  output logic                 out_last_point,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  trd_cmd_t  cmd;
  trd_stat_t stat;

  assign cfg_ready = 1'b1;

  trd_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_line_low(in_line_low),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  trd_dp #(
    .MAX_POINTS (MAX_POINTS),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_report_byte (in_report_byte),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_index(out_point_index),
    .out_point_count(out_point_count),
    .out_point_valid(out_point_valid),
    .out_last_point (out_last_point)
  );

endmodule

/* design/trd_checker.sv */
module trd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_point_x,
  input logic [11:0] out_point_y,
  input logic [2:0]  out_point_index,
  input logic [2:0]  out_point_count,
  input logic        out_point_valid,
  input logic        out_last_point
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_point_x, out_point_y, out_point_index, out_point_count,
               out_point_valid, out_last_point}))
    else $error("output beat changed while stalled");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_last_point && out_point_x == 12'd0 &&
      out_point_y == 12'd0 && out_point_index == 3'd0)
    else $error("bad count marker malformed");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_valid && out_last_point |->
      3'(out_point_index + 3'd1) == out_point_count)
    else $error("last point index does not match count");

  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready |=> !out_valid)
    else $error("result beat one cycle after input beat");

  a_reset_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind touch_report_decoder_core trd_checker u_trd_checker (.*);

/* sim/touch_report_decoder_core_tb.sv */
`timescale 1ns / 1ps

module touch_report_decoder_core_tb;
  import trd_pkg::*;

  localparam int NPTS          = MAX_POINTS_DEF;
  localparam int FRAME_LEN     = HEAD_BYTES + POINT_BYTES * NPTS;
  localparam int STORE_DEPTH   = FRAME_BYTES_DEF;
  localparam int POS_MOD       = 1 << POS_W;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  typedef enum logic {CMD_SAMPLE, CMD_BYTE} command_t;
  typedef enum logic [1:0] {FRAME_IDLE, FRAME_NEW, FRAME_HELD} frame_mode_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_EDGE} fill_t;
  typedef enum logic [1:0] {ROW_SAMPLE, ROW_BYTE, ROW_FRAME} row_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [2:0]         idx;
    logic [2:0]         cnt;
    logic               valid;
    logic               last;
  } point_t;

  typedef struct packed {
    command_t   cmd;
    logic       low;
    logic [7:0] data;
    logic       typed;
    point_t     want;
  } beat_t;

  typedef struct packed {
    row_t       kind;
    logic       low;
    logic [7:0] val;
    fill_t      fill;
    int         len;
    logic       typed;
    point_t     want;
  } step_row_t;

  typedef struct packed {
    logic [ROT_W-1:0]  rot;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } screen_cfg_t;

  localparam point_t NO_PT  = '0;
  localparam point_t BAD_C0 = '{12'd0, 12'd0, 3'd0, 3'd0, 1'b0, 1'b1};
  localparam point_t BAD_C3 = '{12'd0, 12'd0, 3'd0, 3'd3, 1'b0, 1'b1};
  localparam point_t BAD_C5 = '{12'd0, 12'd0, 3'd0, 3'd5, 1'b0, 1'b1};

  localparam int NROWS = 27;
  localparam step_row_t PLAN [NROWS] = '{
    '{ROW_BYTE,   1'b0, 8'hA5, FILL_ZERO, 0,  1'b0, NO_PT},  // no frame open
    '{ROW_SAMPLE, 1'b0, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},  // high after high
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},  // new touch
    '{ROW_FRAME,  1'b0, 8'd0,  FILL_RAND, 32, 1'b1, BAD_C0},
    '{ROW_SAMPLE, 1'b0, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd5,  FILL_ONES, 32, 1'b0, NO_PT},  // all points, saturation
    '{ROW_BYTE,   1'b0, 8'h5A, FILL_ZERO, 0,  1'b0, NO_PT},  // frame closed
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},  // held touch
    '{ROW_FRAME,  1'b0, 8'd6,  FILL_RAND, 32, 1'b1, BAD_C5},
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd255, FILL_ONES, 32, 1'b1, BAD_C5},
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd2,  FILL_RAND, 17, 1'b0, NO_PT},  // cut by low sample
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd1,  FILL_ZERO, 32, 1'b0, NO_PT},
    '{ROW_SAMPLE, 1'b0, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},  // high after low
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd4,  FILL_RAND, 20, 1'b0, NO_PT},  // cut by high sample
    '{ROW_SAMPLE, 1'b0, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_SAMPLE, 1'b0, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},  // clears count
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd7,  FILL_RAND, 32, 1'b1, BAD_C0},
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd3,  FILL_EDGE, 32, 1'b0, NO_PT},
    '{ROW_SAMPLE, 1'b1, 8'h00, FILL_ZERO, 0,  1'b0, NO_PT},
    '{ROW_FRAME,  1'b0, 8'd0,  FILL_ONES, 32, 1'b1, BAD_C3}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic                 in_line_low;
  logic [7:0]           in_report_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [COORD_W-1:0]   out_point_x;
  logic [COORD_W-1:0]   out_point_y;
  logic [2:0]           out_point_index;
  logic [2:0]           out_point_count;
  logic                 out_point_valid;
  logic                 out_last_point;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  touch_report_decoder_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_line_low    (in_line_low),
    .in_report_byte (in_report_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_index(out_point_index),
    .out_point_count(out_point_count),
    .out_point_valid(out_point_valid),
    .out_last_point (out_last_point),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  beat_t  beats_to_send [$];
  beat_t  beats_in_flight [$];
  point_t pending_points [$];
  int     fail_count  = 0;
  int     cycle_count = 0;

  // decoder state as predicted
  logic              line_high;
  frame_mode_t       fmode;
  int                fpos;
  logic [7:0]        frame_bytes [STORE_DEPTH];
  logic [2:0]        touches;
  logic [ROT_W-1:0]  rot_cfg;
  logic [SIZE_W-1:0] width_cfg;
  logic [SIZE_W-1:0] height_cfg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [COORD_W-1:0] flip_coord(input int size, input int v);
    int r;
    r = size - 1 - v;
    if (r < 0) begin
      return '0;
    end
    if (r > COORD_MAX) begin
      return COORD_MAX[COORD_W-1:0];
    end
    return r[COORD_W-1:0];
  endfunction

  task automatic finish_frame(input logic typed, input point_t typed_pt);
    int n, base;
    logic held;
    logic [COORD_W-1:0] x, y;
    point_t pt;
    n    = frame_bytes[1];
    held = (fmode == FRAME_HELD);
    fmode = FRAME_IDLE;
    fpos  = 0;
    if (n == 0 || n > NPTS) begin
      if (!held) begin
        touches = '0;
      end
      pt = '{12'd0, 12'd0, 3'd0, touches, 1'b0, 1'b1};
      pending_points.push_back(typed ? typed_pt : pt);
    end else begin
      touches = n[2:0];
      for (int k = 0; k < n; k++) begin
        base = HEAD_BYTES + POINT_BYTES * k;
        x = {frame_bytes[base][NIB_W-1:0], frame_bytes[base + 1]};
        y = {frame_bytes[base + 2][NIB_W-1:0], frame_bytes[base + 3]};
        pt.idx   = k[2:0];
        pt.cnt   = touches;
        pt.valid = 1'b1;
        pt.last  = (k == n - 1);
        case (rot_cfg)
          ROT_PORTRAIT: begin
            pt.x = flip_coord(width_cfg, x);
            pt.y = y;
          end
          ROT_LAND_RIGHT: begin
            pt.x = y;
            pt.y = x;
          end
          ROT_FLIPPED: begin
            pt.x = x;
            pt.y = flip_coord(height_cfg, y);
          end
          default: begin
            pt.x = flip_coord(width_cfg, y);
            pt.y = flip_coord(height_cfg, x);
          end
        endcase
        pending_points.push_back(pt);
      end
    end
  endtask

  task automatic decode_beat(input beat_t b);
    if (b.cmd == CMD_SAMPLE) begin
      fpos = 0;
      if (b.low) begin
        fmode = line_high ? FRAME_NEW : FRAME_HELD;
      end else begin
        fmode = FRAME_IDLE;
        if (line_high) begin
          touches = '0;
        end
      end
      line_high = !b.low;
    end else if (fmode != FRAME_IDLE) begin
      if (fpos < STORE_DEPTH) begin
        frame_bytes[fpos] = b.data;
      end
      fpos = (fpos + 1) % POS_MOD;
      if (fpos >= FRAME_LEN) begin
        finish_frame(b.typed, b.want);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input point_t want, input point_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t %s: exp x=%0d y=%0d idx=%0d cnt=%0d v=%0d last=%0d", $time, what,
               want.x, want.y, want.idx, want.cnt, want.valid, want.last);
      $display("      got x=%0d y=%0d idx=%0d cnt=%0d v=%0d last=%0d",
               got.x, got.y, got.idx, got.cnt, got.valid, got.last);
    end
  endtask

  // checker and predictor, all on pre-edge values
  always @(posedge clk) begin : monitor
    point_t got, want;
    beat_t  acc;
    if (!rst_n) begin
      line_high  = 1'b1;
      fmode      = FRAME_IDLE;
      fpos       = 0;
      touches    = '0;
      rot_cfg    = ROT_PORTRAIT;
      width_cfg  = WIDTH_RST;
      height_cfg = HEIGHT_RST;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_point_x, out_point_y, out_point_index, out_point_count,
                out_point_valid, out_last_point};
        if (pending_points.size() == 0) begin
          note_mismatch("unexpected point beat", NO_PT, got);
        end else begin
          want = pending_points.pop_front();
          if (got !== want) begin
            note_mismatch("point mismatch", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROTATION: rot_cfg    = cfg_data[ROT_W-1:0];
          CFG_WIDTH:    width_cfg  = cfg_data;
          CFG_HEIGHT:   height_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        acc = beats_in_flight.pop_front();
        decode_beat(acc);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender: bursts with random gaps
  initial begin : sender
    int    gap_left, burst_left;
    beat_t b;
    in_valid       <= 1'b0;
    in_command     <= CMD_SAMPLE;
    in_line_low    <= 1'b0;
    in_report_byte <= '0;
    gap_left   = 0;
    burst_left = $urandom_range(1, 40);
    forever begin
      @(posedge clk);
      if (rst_n && (!in_valid || in_ready)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (beats_to_send.size() > 0) begin
          b = beats_to_send.pop_front();
          beats_in_flight.push_back(b);
          in_command     <= b.cmd;
          in_line_low    <= b.low;
          in_report_byte <= b.data;
          in_valid       <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin : receiver
    int cyc;
    out_ready <= 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      case ((cyc / 97) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= (cyc % 5) != 0;
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic logic [7:0] fill_byte(input fill_t f);
    case (f)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_RAND: return 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 4))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'h0F;
          3:       return 8'hF0;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  task automatic add_sample(input logic low);
    beats_to_send.push_back('{CMD_SAMPLE, low, 8'($urandom_range(0, 255)), 1'b0, NO_PT});
  endtask

  task automatic add_byte(input logic [7:0] val, input logic typed, input point_t want);
    beats_to_send.push_back('{CMD_BYTE, 1'($urandom_range(0, 1)), val, typed, want});
  endtask

  task automatic add_frame(input logic [7:0] cnt, input fill_t fill, input int len,
                           input logic typed, input point_t want);
    for (int i = 0; i < len; i++) begin
      add_byte((i == 1) ? cnt : fill_byte(fill), typed && (i == len - 1), want);
    end
  endtask

  // mostly complete reports, some line noise and truncated frames
  task automatic queue_random(input int min_pts);
    int made, n, k;
    logic [7:0] cnt;
    made = 0;
    while (made < min_pts) begin
      if ($urandom_range(0, 4) == 0) begin
        add_sample(1'($urandom_range(0, 1)));
        n = $urandom_range(0, FRAME_LEN - 3);
        for (k = 0; k < n; k++) begin
          add_byte(8'($urandom_range(0, 255)), 1'b0, NO_PT);
        end
      end else begin
        k = $urandom_range(0, 9);
        if (k < 4) begin
          add_sample(1'b0);
        end
        if (k == 0) begin
          add_sample(1'b0);
        end
        add_sample(1'b1);
        if ($urandom_range(0, 6) == 0) begin
          cnt = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(NPTS + 1, 255));
        end else begin
          cnt = 8'($urandom_range(1, NPTS));
        end
        add_frame(cnt, $urandom_range(0, 1) ? FILL_EDGE : FILL_RAND, FRAME_LEN, 1'b0, NO_PT);
        made += (cnt >= 1 && cnt <= NPTS) ? int'(cnt) : 1;
      end
    end
  endtask

  task automatic wait_idle();
    while (beats_to_send.size() > 0 || beats_in_flight.size() > 0 ||
           pending_points.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    step_row_t   r;
    screen_cfg_t screens [$];
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROTATION;
    cfg_data  <= '0;
    screens.push_back('{ROT_LAND_RIGHT, 13'd4096, 13'd4096});
    screens.push_back('{ROT_FLIPPED,    13'd1,    13'd1});
    screens.push_back('{ROT_LAND_LEFT,  13'd4096, 13'd1});
    screens.push_back('{ROT_PORTRAIT,   13'd1,    13'd4096});
    screens.push_back('{ROT_LAND_LEFT,  13'd8191, 13'd0});
    screens.push_back('{ROT_PORTRAIT,   13'd0,    13'd8191});
    screens.push_back('{ROT_FLIPPED,    13'd240,  13'd135});
    screens.push_back('{ROT_LAND_LEFT,  13'($urandom_range(1, 4096)),
                        13'($urandom_range(1, 4096))});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      r = PLAN[i];
      case (r.kind)
        ROW_SAMPLE: add_sample(r.low);
        ROW_BYTE:   add_byte(r.val, 1'b0, NO_PT);
        default:    add_frame(r.val, r.fill, r.len, r.typed, r.want);
      endcase
    end
    queue_random(10);

    foreach (screens[p]) begin
      wait_idle();
      write_reg(CFG_ROTATION, SIZE_W'(screens[p].rot));
      write_reg(CFG_WIDTH, screens[p].w);
      write_reg(CFG_HEIGHT, screens[p].h);
      queue_random(10);
    end

    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/trd_pkg.sv
design/trd_ctrl.sv
design/trd_dp.sv
design/touch_report_decoder_core.sv
design/trd_checker.sv
sim/touch_report_decoder_core_tb.sv
